// ----- sv/hpid_pkg.sv -----
// Shared types and constants for the heading PID with angle wrap.
// Used by hpid_cfg_regs, hpid_err_wrap and heading_pid_with_angle_wrap.
package hpid_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int GAIN_FRAC_BITS_DEF  = 8;

    localparam int ANGLE_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int LIMIT_W   = 15;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DEG_HALF = 180;
    localparam int DEG_FULL = 360;

    localparam logic [GAIN_W-1:0]  RESET_KP        = 24'd23040;
    localparam logic [GAIN_W-1:0]  RESET_KI        = 24'd0;
    localparam logic [GAIN_W-1:0]  RESET_KD        = 24'd102400;
    localparam logic [LIMIT_W-1:0] RESET_INT_LIMIT = 15'd2000;
    localparam logic [LIMIT_W-1:0] RESET_OUT_LIMIT = 15'd7000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP      = 3'd0,
        CFG_GAIN_INTEGRAL  = 3'd1,
        CFG_GAIN_DERIV     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } hpid_cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] int_limit;
        logic [LIMIT_W-1:0] out_limit;
    } hpid_cfg_t;

endpackage

// ----- sv/hpid_cfg_regs.sv -----
// Configuration register file for the heading PID: gains and clamp limits.
// Depends on hpid_pkg for the register indexes, widths and reset values.
module hpid_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpid_pkg::GAIN_W-1:0]     cfg_data,
    output hpid_pkg::hpid_cfg_t             cfg
);
    import hpid_pkg::*;

    hpid_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp        <= RESET_KP;
            cfg_reg.ki        <= RESET_KI;
            cfg_reg.kd        <= RESET_KD;
            cfg_reg.int_limit <= RESET_INT_LIMIT;
            cfg_reg.out_limit <= RESET_OUT_LIMIT;
        end else if (cfg_valid) begin
            // Writes to an index beyond the register list are dropped.
            unique case (hpid_cfg_idx_t'(cfg_index))
                CFG_GAIN_PROP:      cfg_reg.kp        <= cfg_data;
                CFG_GAIN_INTEGRAL:  cfg_reg.ki        <= cfg_data;
                CFG_GAIN_DERIV:     cfg_reg.kd        <= cfg_data;
                CFG_INTEGRAL_LIMIT: cfg_reg.int_limit <= cfg_data[LIMIT_W-1:0];
                CFG_OUTPUT_LIMIT:   cfg_reg.out_limit <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/hpid_err_wrap.sv -----
// Heading error: target minus measured, wrapped once by a full turn and
// saturated to the angle width. Depends on hpid_pkg for widths and degrees.
module hpid_err_wrap #(
    parameter int ANGLE_FRAC_BITS = hpid_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic signed [hpid_pkg::ANGLE_W-1:0] target_angle,
    input  logic signed [hpid_pkg::ANGLE_W-1:0] measured_angle,
    output logic signed [hpid_pkg::ANGLE_W-1:0] wrapped_error
);
    import hpid_pkg::*;

    localparam int HALF_VAL = DEG_HALF << ANGLE_FRAC_BITS;
    localparam int FULL_VAL = DEG_FULL << ANGLE_FRAC_BITS;
    // Wide enough for both the raw difference of two angles and a full turn.
    localparam int FULL_W   = $clog2(FULL_VAL);
    localparam int ERR_W    = ((FULL_W > ANGLE_W) ? FULL_W : ANGLE_W) + 3;

    localparam logic signed [ERR_W-1:0] HALF_C  = ERR_W'(HALF_VAL);
    localparam logic signed [ERR_W-1:0] FULL_C  = ERR_W'(FULL_VAL);
    localparam logic signed [ERR_W-1:0] SAT_MAX = ERR_W'((1 << (ANGLE_W - 1)) - 1);
    localparam logic signed [ERR_W-1:0] SAT_MIN = -ERR_W'(1 << (ANGLE_W - 1));

    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] wrapped;

    always_comb begin
        diff = ERR_W'(target_angle) - ERR_W'(measured_angle);
        if (diff > HALF_C) begin
            wrapped = diff - FULL_C;
        end else if (diff < -HALF_C) begin
            wrapped = diff + FULL_C;
        end else begin
            wrapped = diff;
        end
        if (wrapped > SAT_MAX) begin
            wrapped_error = SAT_MAX[ANGLE_W-1:0];
        end else if (wrapped < SAT_MIN) begin
            wrapped_error = SAT_MIN[ANGLE_W-1:0];
        end else begin
            wrapped_error = wrapped[ANGLE_W-1:0];
        end
    end

endmodule

// ----- sv/heading_pid_with_angle_wrap.sv -----
// Heading PID with angle wrap: a five-stage pipeline that takes one item per cycle
// while the output side is ready and returns one result per item. The stages are
// input register, error wrap, the three gain multipliers, integral update (a loop
// through one add and clamp) and the final sum, shift, clamp and negate. A stalled
// output backs up through the stages, so new items are still taken while empty
// stages remain. Uses hpid_pkg, hpid_cfg_regs and hpid_err_wrap.
module heading_pid_with_angle_wrap #(
    parameter int ANGLE_FRAC_BITS = hpid_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS  = hpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // target_angle, measured_angle
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // drive_value, wrapped_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpid_pkg::GAIN_W-1:0]     cfg_data
);
    import hpid_pkg::*;

    localparam int TERM_FRAC_BITS = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int P_W    = GAIN_W + 1 + ANGLE_W;        // kp * error
    localparam int D_W    = GAIN_W + 1 + ANGLE_W + 1;    // kd * error change
    localparam int INT_W  = LIMIT_W + TERM_FRAC_BITS + 1;
    localparam int SUM_W  = ((D_W > INT_W) ? D_W : INT_W) + 2;

    hpid_cfg_t cfg;

    hpid_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valid bits and the ready chain running back from the output.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: input register.
    logic signed [ANGLE_W-1:0] tgt1_reg, meas1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            tgt1_reg  <= s_tdata[ANGLE_W-1:0];
            meas1_reg <= s_tdata[2*ANGLE_W-1:ANGLE_W];
        end
    end

    // Stage 2: wrapped error, paired with the error of the item before it.
    logic signed [ANGLE_W-1:0] err_wrap;
    logic signed [ANGLE_W-1:0] err2_reg, prev2_reg, prev_error_reg;

    hpid_err_wrap #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_wrap (
        .target_angle   (tgt1_reg),
        .measured_angle (meas1_reg),
        .wrapped_error  (err_wrap)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
        end else if (rdy2 && v1_reg) begin
            prev_error_reg <= err_wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            err2_reg  <= err_wrap;
            prev2_reg <= prev_error_reg;
        end
    end

    // Stage 3: gain products.
    logic signed [ANGLE_W:0]   diff2;
    logic                      flip2;
    logic signed [P_W-1:0]     p3_reg, i3_reg;
    logic signed [D_W-1:0]     d3_reg;
    logic signed [ANGLE_W-1:0] err3_reg;
    logic                      flip3_reg;

    assign diff2 = (ANGLE_W + 1)'(err2_reg) - (ANGLE_W + 1)'(prev2_reg);
    // The integral restarts when the error strictly changes sign.
    assign flip2 = (prev2_reg > 0 && err2_reg < 0) || (prev2_reg < 0 && err2_reg > 0);

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            p3_reg    <= P_W'($signed({1'b0, cfg.kp})) * P_W'(err2_reg);
            i3_reg    <= P_W'($signed({1'b0, cfg.ki})) * P_W'(err2_reg);
            d3_reg    <= D_W'($signed({1'b0, cfg.kd})) * D_W'(diff2);
            err3_reg  <= err2_reg;
            flip3_reg <= flip2;
        end
    end

    // Stage 4: integral accumulate, clamp and sign-change reset.
    logic signed [SUM_W-1:0]   ilim;
    logic signed [SUM_W-1:0]   int_sum;
    logic signed [INT_W-1:0]   integral_next;
    logic signed [INT_W-1:0]   integral_acc_reg;
    logic signed [P_W-1:0]     p4_reg;
    logic signed [D_W-1:0]     d4_reg;
    logic signed [ANGLE_W-1:0] err4_reg;

    always_comb begin
        ilim    = SUM_W'({1'b0, cfg.int_limit}) <<< TERM_FRAC_BITS;
        int_sum = SUM_W'(integral_acc_reg) + SUM_W'(i3_reg);
        if (flip3_reg) begin
            integral_next = '0;
        end else if (int_sum > ilim) begin
            integral_next = ilim[INT_W-1:0];
        end else if (int_sum < -ilim) begin
            integral_next = -ilim[INT_W-1:0];
        end else begin
            integral_next = int_sum[INT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_acc_reg <= '0;
        end else if (rdy4 && v3_reg) begin
            integral_acc_reg <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            p4_reg   <= p3_reg;
            d4_reg   <= d3_reg;
            err4_reg <= err3_reg;
        end
    end

    // Stage 5: sum, floor shift to drive units, clamp and negate.
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   scaled;
    logic signed [SUM_W-1:0]   olim;
    logic signed [SUM_W-1:0]   clamped;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [DRIVE_W-1:0] drive5_reg;
    logic signed [ANGLE_W-1:0] err5_reg;

    always_comb begin
        total  = SUM_W'(p4_reg) + SUM_W'(integral_acc_reg) + SUM_W'(d4_reg);
        scaled = total >>> TERM_FRAC_BITS;
        olim   = SUM_W'({1'b0, cfg.out_limit});
        if (scaled > olim) begin
            clamped = olim;
        end else if (scaled < -olim) begin
            clamped = -olim;
        end else begin
            clamped = scaled;
        end
        drive_next = DRIVE_W'(-clamped);
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            drive5_reg <= drive_next;
            err5_reg   <= err4_reg;
        end
    end

    assign m_tdata = {err5_reg, drive5_reg};

    // The drive is clamped to the 15-bit limit, so the most negative code never appears.
    a_drive_not_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("drive_value reached the most negative code");

    // A sign change of the error leaves the integral at zero.
    a_flip_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (rdy4 && v3_reg && flip3_reg) |=> integral_acc_reg == '0)
        else $error("integral not cleared on error sign change");

    // A result only appears when stage four held an item.
    a_out_from_s4: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v4_reg))
        else $error("result appeared without an item in stage four");

    // An item held in stage one while stage two is blocked keeps its angles.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !rdy2) |=> v1_reg && $stable(tgt1_reg) && $stable(meas1_reg))
        else $error("stage one item changed while stalled");

endmodule
